[rtl/fccl_pkg.sv]
// Shared types and constants for the FAT cluster chain locator.
// No dependencies; imported by the locator top level.
package fccl_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    // register indexes of the configuration port
    localparam logic [1:0] REG_FS_KIND     = 2'd0;
    localparam logic [1:0] REG_SPC         = 2'd1;
    localparam logic [1:0] REG_DATA_START  = 2'd2;
    localparam logic [1:0] REG_RESERVED    = 2'd3;

    // volume types
    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;

    // request kinds on the input stream
    localparam logic REQ_LOCATE = 1'b0;
    localparam logic REQ_REPLY  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_FETCH = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [15:0] FAT12_MASK = 16'h0fff;
    localparam logic [15:0] FAT12_EOC  = 16'h0ff7;
    localparam logic [15:0] FAT16_EOC  = 16'hfff7;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] sector_address;
        logic [8:0]  byte_offset;
    } result_t;

endpackage

[rtl/fccl_divider.sv]
// Restoring 16-bit by 8-bit divider, one quotient bit per cycle.
// No dependencies; used by the locator top level.
module fccl_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic        busy,
    output logic [15:0] quotient,
    output logic [7:0]  remainder
);
    logic [7:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [7:0]  div_reg;
    logic [3:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [8:0]  shifted;
    logic        ge;
    logic [8:0]  diff;

    assign shifted = {rem_reg, quo_reg[15]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 4'd1;
                if (count_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[7:0] : shifted[7:0];
            quo_reg <= {quo_reg[14:0], ge};
        end
    end

    assign done      = done_reg;
    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/fat_cluster_chain_locator_top.sv]
// FAT cluster chain locator top level; uses fccl_pkg and fccl_divider.
// Locate: accept, divider steps, divider handoff, address step, output load.
//   Reply: accept, address step, output load. Error results: accept, output load.
// One request in work at a time: s_tready is low from accept until the result is loaded,
//   and a full output register holds the load; so a new request waits for the last result.
// rst_n (async, low) clears sequencer, chain state, output valid; fs_kind 2, 1 sector/cluster.
module fat_cluster_chain_locator_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] start_cluster, [31:16] file_sector, [47:32] fat_word, [48] fetch_failed
    input  logic [55:0] s_tdata,
    // [0] req_type
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] sector_address, [24:16] byte_offset
    output logic [31:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);
    import fccl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ADV,
        S_EMIT
    } state_t;

    // configuration registers (data area start and reserved count reset to 0 and 1)
    logic [1:0]  fs_kind_reg;
    logic [7:0]  spc_reg;
    logic [15:0] data_base_reg;
    logic [15:0] reserved_reg;

    // chain walk state
    state_t      state_reg;
    logic [15:0] cluster_reg;
    logic [15:0] hops_reg;
    logic [7:0]  offset_reg;
    logic        awaiting_reg;

    // pending result and output register
    result_t     res_reg;
    result_t     out_reg;
    logic        m_tvalid_reg;

    // request fields
    logic        req_type;
    logic [15:0] start_cluster;
    logic [15:0] file_sector;
    logic [15:0] fat_word;
    logic        fetch_failed;

    assign req_type      = s_tuser[0];
    assign start_cluster = s_tdata[15:0];
    assign file_sector   = s_tdata[31:16];
    assign fat_word      = s_tdata[47:32];
    assign fetch_failed  = s_tdata[48];

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // result moves into the output register when that is empty or draining
    logic emit_load;
    assign emit_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // divider: file_sector / sectors per cluster
    logic        div_start;
    logic        div_done;
    logic        div_busy;
    logic [15:0] div_quo;
    logic [7:0]  div_rem;

    logic kind_bad;
    assign kind_bad  = fs_kind_reg > KIND_FAT16;
    assign div_start = accept && (req_type == REQ_LOCATE) && !kind_bad && (spc_reg != 8'd0);

    fccl_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (file_sector),
        .divisor   (spc_reg),
        .done      (div_done),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // next cluster from the fetched FAT word
    logic [15:0] next_cluster;
    logic        end_of_chain;

    always_comb
    begin
        if (fs_kind_reg == KIND_FAT12)
        begin
            next_cluster = cluster_reg[0] ? (fat_word >> 4) : (fat_word & FAT12_MASK);
            end_of_chain = next_cluster >= FAT12_EOC;
        end
        else
        begin
            next_cluster = fat_word;
            end_of_chain = next_cluster >= FAT16_EOC;
        end
    end

    // address step: data sector, or FAT sector and byte of the current entry
    logic [15:0] cl_rel;
    logic [23:0] product;
    logic [15:0] data_sector;
    logic [16:0] fat_off;
    logic [15:0] fat_lba;

    assign cl_rel      = cluster_reg - 16'd2;
    assign product     = cl_rel * spc_reg;
    assign data_sector = product[15:0] + data_base_reg + {8'd0, offset_reg};
    assign fat_off     = (fs_kind_reg == KIND_FAT12)
                         ? ({1'b0, cluster_reg} + {2'b0, cluster_reg[15:1]})
                         : {cluster_reg, 1'b0};
    assign fat_lba     = reserved_reg
                         + {{(16 - (17 - SECTOR_SHIFT)){1'b0}}, fat_off[16:SECTOR_SHIFT]};

    localparam result_t ERR_RESULT = '{status: ST_ERROR, sector_address: 16'd0,
                                       byte_offset: 9'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_kind_reg   <= 2'd2;
            spc_reg       <= 8'd1;
            data_base_reg <= 16'd0;
            reserved_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FS_KIND:    fs_kind_reg   <= cfg_data[1:0];
                REG_SPC:        spc_reg       <= cfg_data[7:0];
                REG_DATA_START: data_base_reg <= cfg_data;
                REG_RESERVED:   reserved_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cluster_reg  <= '0;
            hops_reg     <= '0;
            offset_reg   <= '0;
            awaiting_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            res_reg      <= ERR_RESULT;
            out_reg      <= ERR_RESULT;
        end
        else
        begin
            if (emit_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_LOCATE)
                        begin
                            awaiting_reg <= 1'b0;
                            if (div_start)
                            begin
                                cluster_reg <= start_cluster;
                                state_reg   <= S_DIV;
                            end
                            else
                            begin
                                res_reg   <= ERR_RESULT;
                                state_reg <= S_EMIT;
                            end
                        end
                        else if (!awaiting_reg)
                        begin
                            // stray reply: error, walk state untouched
                            res_reg   <= ERR_RESULT;
                            state_reg <= S_EMIT;
                        end
                        else if (kind_bad || fetch_failed || end_of_chain)
                        begin
                            awaiting_reg <= 1'b0;
                            res_reg      <= ERR_RESULT;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            cluster_reg <= next_cluster;
                            hops_reg    <= hops_reg - 16'd1;
                            state_reg   <= S_ADV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        hops_reg   <= div_quo;
                        offset_reg <= div_rem;
                        state_reg  <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    if (hops_reg == 16'd0)
                    begin
                        awaiting_reg <= 1'b0;
                        res_reg      <= '{status: ST_FOUND, sector_address: data_sector,
                                          byte_offset: 9'd0};
                    end
                    else
                    begin
                        awaiting_reg <= 1'b1;
                        res_reg      <= '{status: ST_FETCH, sector_address: fat_lba,
                                          byte_offset: fat_off[SECTOR_SHIFT-1:0]};
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.byte_offset, out_reg.sector_address};
    assign m_tuser  = out_reg.status;

    // divider runs only while the sequencer waits on it
    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    // a divide result arrives only in the divide state
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide state");

    // a found sector or an error carries no FAT byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FOUND || m_tuser == ST_ERROR) |-> m_tdata[24:16] == 9'd0)
        else $error("byte offset set on non-fetch result");

    // a fetch request is only issued with the walk waiting on a reply
    a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADV && hops_reg != 16'd0 |=> awaiting_reg)
        else $error("fetch issued without awaiting reply");

endmodule
